// ===== sv/i2cwr_pkg.sv =====
// Package for the I2C master write/read sequencer.
// Holds the item and result types, the request and command codes and fixed constants.
// Depends on nothing; the control, top-level and testbench files import it.
package i2cwr_pkg;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_WRITE = 2'd1,
		PH_READ  = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		REQ_START = 2'd0,
		REQ_LOAD  = 2'd1,
		REQ_EVENT = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		CMD_NONE    = 2'd0,
		CMD_RESTART = 2'd1,
		CMD_STOP    = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		RC_OK      = 2'd0,
		RC_NACK    = 2'd1,
		RC_BUS_ERR = 2'd2
	} rc_t;

	// Direction handling of the address byte.
	localparam logic [7:0] ADDR_WR_MASK = 8'hfe;
	localparam logic [7:0] ADDR_RD_BIT  = 8'h01;

	// A read is never longer than this many bytes.
	localparam logic [5:0] READ_MAX = 6'd32;

	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 40;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] target_addr;
		logic [5:0] write_count;
		logic [5:0] read_count;
		logic       start_blocked;
		logic [4:0] load_index;
		logic [7:0] load_byte;
		logic       rx_nack;
		logic [5:0] error_flags;
		logic [7:0] rx_data;
	} item_t;

	typedef struct packed {
		cmd_t       bus_cmd;
		logic       addr_valid;
		logic [7:0] addr_byte;
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       rd_valid;
		logic [4:0] rd_index;
		logic [7:0] rd_byte;
		logic       nack_next;
		logic       done_res;
		rc_t        result_code;
		logic       rejected;
	} res_t;

endpackage

// ===== sv/i2cwr_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Parameters give the word width and the depth; no package is needed.
module i2cwr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/i2cwr_ctrl.sv =====
// Transfer control of the I2C master write/read sequencer: phase, counts and address.
// Forms each result but the transmitted byte and drives the write store ports.
// Depends on i2cwr_pkg.
module i2cwr_ctrl
	import i2cwr_pkg::*;
#(
	parameter int BUFFER_DEPTH = 32,
	parameter int AW           = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  item_t         item,
	output res_t          res,
	output logic          mem_we,
	output logic [AW-1:0] mem_waddr,
	output logic [7:0]    mem_wdata,
	output logic          mem_re,
	output logic [AW-1:0] mem_raddr
);

	phase_t     phase_q, phase_d;
	logic [7:0] dest_q, dest_d;
	logic [5:0] wpos_q, wpos_d;
	logic [5:0] wleft_q, wleft_d;
	logic [5:0] rleft_q, rleft_d;
	logic [5:0] rpos_q, rpos_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			dest_q  <= '0;
			wpos_q  <= '0;
			wleft_q <= '0;
			rleft_q <= '0;
			rpos_q  <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			dest_q  <= dest_d;
			wpos_q  <= wpos_d;
			wleft_q <= wleft_d;
			rleft_q <= rleft_d;
			rpos_q  <= rpos_d;
		end
	end

	always_comb begin
		logic [5:0] wc;
		logic [5:0] rc;
		logic [5:0] rl_next;
		phase_d = phase_q;
		dest_d  = dest_q;
		wpos_d  = wpos_q;
		wleft_d = wleft_q;
		rleft_d = rleft_q;
		rpos_d  = rpos_q;
		res     = '0;
		wc      = item.write_count;
		rc      = item.read_count;
		rl_next = rleft_q;
		if (32'(item.write_count) > BUFFER_DEPTH) begin
			wc = 6'(BUFFER_DEPTH);
		end
		if (item.read_count > READ_MAX) begin
			rc = READ_MAX;
		end
		case (item.req_type)
			REQ_START: begin
				if (item.start_blocked) begin
					res.rejected = 1'b1;
				end else begin
					dest_d  = item.target_addr;
					wpos_d  = '0;
					rpos_d  = '0;
					wleft_d = wc;
					rleft_d = rc;
					if (wc == '0 && rc == '0) begin
						phase_d      = PH_IDLE;
						res.done_res = 1'b1;
					end else begin
						res.nack_next  = (rc == 6'd1);
						res.addr_valid = 1'b1;
						if (wc != '0) begin
							phase_d       = PH_WRITE;
							res.addr_byte = item.target_addr & ADDR_WR_MASK;
						end else begin
							phase_d       = PH_READ;
							res.addr_byte = item.target_addr | ADDR_RD_BIT;
						end
					end
				end
			end
			REQ_EVENT: begin
				if (phase_q == PH_WRITE || phase_q == PH_READ) begin
					if (item.error_flags != '0) begin
						res.bus_cmd     = CMD_STOP;
						res.done_res    = 1'b1;
						res.result_code = RC_BUS_ERR;
						phase_d         = PH_IDLE;
					end else if (item.rx_nack) begin
						res.bus_cmd     = CMD_STOP;
						res.done_res    = 1'b1;
						res.result_code = RC_NACK;
						phase_d         = PH_IDLE;
					end else if (phase_q == PH_WRITE) begin
						if (wleft_q != '0) begin
							// The byte itself arrives later from the store's registered read port.
							res.tx_valid  = 1'b1;
							res.nack_next = (rleft_q == 6'd1);
							wpos_d        = wpos_q + 6'd1;
							wleft_d       = wleft_q - 6'd1;
						end else if (rleft_q == '0) begin
							res.bus_cmd  = CMD_STOP;
							res.done_res = 1'b1;
							phase_d      = PH_IDLE;
						end else begin
							res.bus_cmd    = CMD_RESTART;
							res.addr_valid = 1'b1;
							res.addr_byte  = dest_q | ADDR_RD_BIT;
							res.nack_next  = (rleft_q == 6'd1);
							phase_d        = PH_READ;
						end
					end else begin
						res.rd_valid = 1'b1;
						res.rd_index = rpos_q[4:0];
						res.rd_byte  = item.rx_data;
						rpos_d       = rpos_q + 6'd1;
						if (rleft_q != '0) begin
							rl_next = rleft_q - 6'd1;
						end
						rleft_d = rl_next;
						if (rl_next == '0) begin
							res.bus_cmd  = CMD_STOP;
							res.done_res = 1'b1;
							phase_d      = PH_IDLE;
						end else begin
							res.nack_next = (rl_next == 6'd1);
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Loads write at the same stage as events read, so an event always sees
	// every earlier load without any bypass.
	assign mem_we    = accept && item.req_type == REQ_LOAD
	                   && 32'(item.load_index) < BUFFER_DEPTH;
	assign mem_waddr = AW'(item.load_index);
	assign mem_wdata = item.load_byte;
	assign mem_re    = accept;
	assign mem_raddr = AW'(wpos_q);

endmodule

// ===== sv/i2c_master_write_read_sequencer.sv =====
// I2C master write/read sequencer, top level: stream ports, pipeline and output register.
// Depends on i2cwr_pkg, i2cwr_ctrl and i2cwr_ram.
//
// The block sequences one I2C master transfer at a time: bytes are first loaded into a
// write store of BUFFER_DEPTH entries, a start transaction then opens a write of up to
// BUFFER_DEPTH bytes followed by an optional repeated-start read of up to 32 bytes, and
// each bus event transaction advances the transfer by one step. Every input transaction
// yields exactly one output transaction, in order. The block accepts one transaction per
// clock cycle, back to back, unless the output stalls; a result goes through stage 1 and
// then the output register, as the write store is a synchronous memory with a registered
// read port returning the byte to be sent at the given address. The output register and
// the stage holding the pending memory read let a new transaction be taken while a
// finished result still waits on the output side. The write store is not cleared at
// reset and needs no clearing pass: a byte sent from an entry that was never loaded is
// undefined. Loads are taken in any phase; a load beyond the store depth is dropped.
module i2c_master_write_read_sequencer
	import i2cwr_pkg::*;
#(
	parameter int BUFFER_DEPTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// target_addr[7:0], write_count[13:8], read_count[19:14], start_blocked[20],
	// load_index[25:21], load_byte[33:26], rx_nack[34], error_flags[40:35],
	// rx_data[48:41], zero fill[55:49]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// req_type[1:0]
	input  logic [1:0]            s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// bus_cmd[1:0], addr_valid[2], addr_byte[10:3], tx_valid[11], tx_byte[19:12],
	// rd_valid[20], rd_index[25:21], rd_byte[33:26], nack_next[34], done_res[35],
	// result_code[37:36], rejected[38], zero fill[39]
	output logic [OUT_DATA_W-1:0] m_tdata
);

	localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

	item_t         item;
	res_t          ctrl_res;
	logic          accept;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0]    mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [7:0]    mem_rdata;

	// Stage 1 waits for the store read; the output register holds a finished result.
	logic          valid_s1;
	res_t          res_s1;
	logic          out_valid_q;
	res_t          out_q;
	res_t          res_full;
	logic          advance;

	assign item.req_type      = s_tuser;
	assign item.target_addr   = s_tdata[7:0];
	assign item.write_count   = s_tdata[13:8];
	assign item.read_count    = s_tdata[19:14];
	assign item.start_blocked = s_tdata[20];
	assign item.load_index    = s_tdata[25:21];
	assign item.load_byte     = s_tdata[33:26];
	assign item.rx_nack       = s_tdata[34];
	assign item.error_flags   = s_tdata[40:35];
	assign item.rx_data       = s_tdata[48:41];

	// Stage 1 moves on whenever the output register is empty or being emptied.
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign accept   = s_tvalid && s_tready;

	i2cwr_ctrl #(
		.BUFFER_DEPTH(BUFFER_DEPTH),
		.AW          (AW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (item),
		.res      (ctrl_res),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re   (mem_re),
		.mem_raddr(mem_raddr)
	);

	// The read enable follows acceptance, so the read data holds while stage 1 stalls.
	i2cwr_ram #(
		.WIDTH(8),
		.DEPTH(BUFFER_DEPTH),
		.AW   (AW)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= ctrl_res;
		end
		if (advance) begin
			out_q <= res_full;
		end
	end

	// The transmitted byte is the only field that comes from the store.
	always_comb begin
		res_full = res_s1;
		res_full.tx_byte = res_s1.tx_valid ? mem_rdata : 8'h00;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_q.rejected, out_q.result_code, out_q.done_res,
	                   out_q.nack_next, out_q.rd_byte, out_q.rd_index, out_q.rd_valid,
	                   out_q.tx_byte, out_q.tx_valid, out_q.addr_byte, out_q.addr_valid,
	                   out_q.bus_cmd};

`ifndef SYNTHESIS
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !m_tready) |-> !s_tready)
		else $error("input taken while the pipeline is full");

	a_one_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> $onehot0({out_q.addr_valid, out_q.tx_valid, out_q.rd_valid}))
		else $error("more than one payload kind in one result");

	a_code_only_when_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.done_res) |-> (out_q.result_code == RC_OK))
		else $error("result code set on an unfinished transfer");

	a_reject_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.rejected) |->
		(!out_q.done_res && !out_q.addr_valid && out_q.bus_cmd == CMD_NONE))
		else $error("rejected start carries bus activity");

	a_no_tx_byte_without_send: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.tx_valid) |-> (out_q.tx_byte == 8'h00))
		else $error("transmit byte present without a send");
`endif

endmodule

// ===== tb/sv/i2c_master_write_read_sequencer_tb.sv =====
// Self-checking testbench for the I2C master write/read sequencer.
// Depends on i2cwr_pkg and i2c_master_write_read_sequencer; drives directed and random
// transfers through the stream ports and checks every result against its own predictor.
module i2c_master_write_read_sequencer_tb
	import i2cwr_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int BUFFER_DEPTH = 32;
	// Cycles without any transaction on either side before the run is declared hung.
	localparam int STALL_LIMIT = 2000;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	// target_addr, write_count, read_count, start_blocked, load_index, load_byte,
	// rx_nack, error_flags, rx_data, zero fill (lowest bit first)
	logic [IN_DATA_W-1:0]  s_tdata;
	// req_type
	logic [1:0]            s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	// bus_cmd, addr_valid, addr_byte, tx_valid, tx_byte, rd_valid, rd_index, rd_byte,
	// nack_next, done_res, result_code, rejected, zero fill (lowest bit first)
	logic [OUT_DATA_W-1:0] m_tdata;

	i2c_master_write_read_sequencer #(
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	// Our own copy of the sequencer state, advanced once per accepted input transaction.
	phase_t     seq_phase;
	logic [7:0] seq_store [BUFFER_DEPTH];
	bit         seq_loaded [BUFFER_DEPTH];
	logic [7:0] seq_dest;
	logic [5:0] seq_wr_pos;
	logic [5:0] seq_wr_left;
	logic [5:0] seq_rd_left;
	logic [5:0] seq_rd_pos;

	// Bus actions predicted for accepted transactions, oldest first.
	res_t bus_actions_due [$];

	int mismatches;
	int items_sent;
	int src_idle_pct;
	int sink_stall_pct;
	int quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// The receiver stalls at random; the rate is changed by each traffic phase.
	initial begin
		m_tready = 1'b0;
		forever @(negedge clk) m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
	end

	// Ends the transfer with a stop and the given outcome; the sequencer returns to idle.
	function automatic void close_transfer(inout res_t r, input rc_t code);
		r.bus_cmd     = CMD_STOP;
		r.done_res    = 1'b1;
		r.result_code = code;
		seq_phase     = PH_IDLE;
	endfunction

	// Works out the single result that one input transaction causes and advances the state.
	function automatic res_t sequencer_step(input item_t it);
		res_t       r;
		logic [5:0] wc;
		logic [5:0] rc;

		r = '0;
		case (it.req_type)
			REQ_START: begin
				if (it.start_blocked) begin
					// The bus is held by slave activity: refuse and keep everything.
					r.rejected = 1'b1;
				end else begin
					wc = (it.write_count > BUFFER_DEPTH) ? 6'(BUFFER_DEPTH) : it.write_count;
					rc = (it.read_count > READ_MAX) ? READ_MAX : it.read_count;
					seq_dest    = it.target_addr;
					seq_wr_pos  = '0;
					seq_rd_pos  = '0;
					seq_wr_left = wc;
					seq_rd_left = rc;
					if (wc == 0 && rc == 0) begin
						// Nothing to move: complete at once without touching the bus.
						seq_phase  = PH_IDLE;
						r.done_res = 1'b1;
					end else begin
						r.nack_next  = (rc == 1);
						r.addr_valid = 1'b1;
						if (wc != 0) begin
							seq_phase   = PH_WRITE;
							r.addr_byte = seq_dest & ADDR_WR_MASK;
						end else begin
							seq_phase   = PH_READ;
							r.addr_byte = seq_dest | ADDR_RD_BIT;
						end
					end
				end
			end
			REQ_LOAD: begin
				seq_store[it.load_index]  = it.load_byte;
				seq_loaded[it.load_index] = 1'b1;
			end
			REQ_EVENT: begin
				if (seq_phase == PH_WRITE || seq_phase == PH_READ) begin
					// A bus error outranks a NACK arriving in the same event.
					if (it.error_flags != 0) begin
						close_transfer(r, RC_BUS_ERR);
					end else if (it.rx_nack) begin
						close_transfer(r, RC_NACK);
					end else if (seq_phase == PH_WRITE) begin
						if (seq_wr_left != 0) begin
							r.tx_valid  = 1'b1;
							r.tx_byte   = seq_store[seq_wr_pos[4:0]];
							seq_wr_pos  = seq_wr_pos + 6'd1;
							seq_wr_left = seq_wr_left - 6'd1;
							r.nack_next = (seq_rd_left == 1);
						end else if (seq_rd_left == 0) begin
							close_transfer(r, RC_OK);
						end else begin
							// Write part finished: turn the bus round with a repeated start.
							r.bus_cmd    = CMD_RESTART;
							r.addr_valid = 1'b1;
							r.addr_byte  = seq_dest | ADDR_RD_BIT;
							r.nack_next  = (seq_rd_left == 1);
							seq_phase    = PH_READ;
						end
					end else begin
						r.rd_valid = 1'b1;
						r.rd_index = seq_rd_pos[4:0];
						r.rd_byte  = it.rx_data;
						seq_rd_pos = seq_rd_pos + 6'd1;
						if (seq_rd_left != 0)
							seq_rd_left = seq_rd_left - 6'd1;
						if (seq_rd_left == 0)
							close_transfer(r, RC_OK);
						else
							r.nack_next = (seq_rd_left == 1);
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// Every field random, the request kind included; callers override what matters.
	function automatic item_t random_item();
		logic [63:0] raw;
		item_t       it;

		raw = {$urandom, $urandom};
		it  = raw[$bits(item_t)-1:0];
		return it;
	endfunction

	function automatic item_t make_start(input logic [7:0] addr, input logic [5:0] wc,
			input logic [5:0] rc, input logic blocked);
		item_t it;

		it               = random_item();
		it.req_type      = REQ_START;
		it.target_addr   = addr;
		it.write_count   = wc;
		it.read_count    = rc;
		it.start_blocked = blocked;
		return it;
	endfunction

	function automatic item_t make_load(input logic [4:0] idx, input logic [7:0] value);
		item_t it;

		it            = random_item();
		it.req_type   = REQ_LOAD;
		it.load_index = idx;
		it.load_byte  = value;
		return it;
	endfunction

	function automatic item_t make_event(input logic nack, input logic [5:0] flags,
			input logic [7:0] data);
		item_t it;

		it             = random_item();
		it.req_type    = REQ_EVENT;
		it.rx_nack     = nack;
		it.error_flags = flags;
		it.rx_data     = data;
		return it;
	endfunction

	// Any kind of transaction, but a start is always a refused one so that no transfer
	// can begin that would send a store entry never loaded.
	function automatic item_t noise_item();
		item_t it;

		it = random_item();
		if (it.req_type == REQ_START)
			it.start_blocked = 1'b1;
		return it;
	endfunction

	// Mostly short transfers, some up to the full store, a few with counts that saturate.
	function automatic logic [5:0] pick_count();
		int roll;

		roll = $urandom_range(0, 99);
		if (roll < 70)
			return 6'($urandom_range(0, 4));
		else if (roll < 90)
			return 6'($urandom_range(5, 32));
		else
			return 6'($urandom_range(33, 63));
	endfunction

	// Offers one transaction, after a random number of idle cycles, and holds it until the
	// block takes it. The prediction is made at the edge where the transaction is accepted.
	task automatic send_item(input item_t it);
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= it.req_type;
		s_tdata  <= {7'b0, it.rx_data, it.error_flags, it.rx_nack, it.load_byte,
			it.load_index, it.start_blocked, it.read_count, it.write_count, it.target_addr};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		bus_actions_due.push_back(sequencer_step(it));
		items_sent++;
	endtask

	// Write of two bytes, turnaround, single-byte read answered with NACK.
	task automatic test_write_then_read();
		send_item(make_load(5'd0, 8'h00));
		send_item(make_load(5'd1, 8'hff));
		send_item(make_load(5'd31, 8'ha5));
		send_item(make_start(8'hff, 6'd2, 6'd1, 1'b0));
		send_item(make_event(1'b0, 6'd0, 8'h00));
		send_item(make_event(1'b0, 6'd0, 8'h00));
		send_item(make_event(1'b0, 6'd0, 8'h00));
		send_item(make_event(1'b0, 6'd0, 8'hff));
	endtask

	// Zero-length transfer, refused start, an event with no transfer running and the
	// unused request kind.
	task automatic test_degenerate_requests();
		item_t it;

		send_item(make_start(8'h00, 6'd0, 6'd0, 1'b0));
		send_item(make_start(8'h3c, 6'd3, 6'd3, 1'b1));
		send_item(make_event(1'b0, 6'd0, 8'h5a));
		it          = random_item();
		it.req_type = 2'd3;
		send_item(it);
	endtask

	// A read-only transfer cut by a slave NACK, a write hit by an error and a NACK together,
	// and a transfer abandoned by a fresh start.
	task automatic test_abort_paths();
		send_item(make_start(8'h00, 6'd0, 6'd2, 1'b0));
		send_item(make_event(1'b1, 6'd0, 8'h11));
		send_item(make_start(8'h81, 6'd1, 6'd0, 1'b0));
		send_item(make_event(1'b1, 6'h3f, 8'h22));
		send_item(make_start(8'h42, 6'd1, 6'd0, 1'b0));
		send_item(make_start(8'h24, 6'd1, 6'd0, 1'b0));
		send_item(make_event(1'b0, 6'd0, 8'h33));
		send_item(make_event(1'b0, 6'd0, 8'h44));
	endtask

	// One well-formed transfer with random content: the store is filled as far as the
	// write needs, then start, then bus events until it ends. Now and then a NACK, an error,
	// a stray transaction or an abandon by the next transfer's start breaks it.
	task automatic run_one_transfer();
		logic [5:0] wc;
		logic [5:0] rc;
		int         nwr;
		int         roll;

		wc  = pick_count();
		rc  = pick_count();
		nwr = (int'(wc) > BUFFER_DEPTH) ? BUFFER_DEPTH : int'(wc);
		for (int i = 0; i < nwr; i++) begin
			if (!seq_loaded[i] || $urandom_range(0, 3) == 0)
				send_item(make_load(5'(i), 8'($urandom_range(0, 255))));
		end
		if ($urandom_range(0, 99) < 5)
			send_item(make_start(8'($urandom_range(0, 255)), wc, rc, 1'b1));
		send_item(make_start(8'($urandom_range(0, 255)), wc, rc, 1'b0));
		while (seq_phase != PH_IDLE) begin
			roll = $urandom_range(0, 99);
			if (roll < 2)
				return;
			else if (roll < 6)
				send_item(noise_item());
			else if (roll < 9)
				send_item(make_event(1'($urandom_range(0, 1)), 6'($urandom_range(1, 63)),
					8'($urandom_range(0, 255))));
			else if (roll < 12)
				send_item(make_event(1'b1, 6'd0, 8'($urandom_range(0, 255))));
			else
				send_item(make_event(1'b0, 6'd0, 8'($urandom_range(0, 255))));
		end
		if ($urandom_range(0, 9) == 0)
			send_item(noise_item());
	endtask

	task automatic test_random_traffic(input int src_pct, input int sink_pct, input int count);
		int first;

		src_idle_pct   = src_pct;
		sink_stall_pct = sink_pct;
		first          = items_sent;
		while (items_sent - first < count)
			run_one_transfer();
	endtask

	function automatic void compare_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
		end
	endfunction

	// Each output transaction is checked against the oldest prediction.
	always @(posedge clk) begin
		res_t want;

		if (arst_n && m_tvalid && m_tready) begin
			if (bus_actions_due.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result, expected none, got %0h", $time, m_tdata);
			end else begin
				want = bus_actions_due.pop_front();
				compare_field("bus_cmd", 8'(want.bus_cmd), 8'(m_tdata[1:0]));
				compare_field("addr_valid", 8'(want.addr_valid), 8'(m_tdata[2]));
				compare_field("addr_byte", want.addr_byte, m_tdata[10:3]);
				compare_field("tx_valid", 8'(want.tx_valid), 8'(m_tdata[11]));
				compare_field("tx_byte", want.tx_byte, m_tdata[19:12]);
				compare_field("rd_valid", 8'(want.rd_valid), 8'(m_tdata[20]));
				compare_field("rd_index", 8'(want.rd_index), 8'(m_tdata[25:21]));
				compare_field("rd_byte", want.rd_byte, m_tdata[33:26]);
				compare_field("nack_next", 8'(want.nack_next), 8'(m_tdata[34]));
				compare_field("done_res", 8'(want.done_res), 8'(m_tdata[35]));
				compare_field("result_code", 8'(want.result_code), 8'(m_tdata[37:36]));
				compare_field("rejected", 8'(want.rejected), 8'(m_tdata[38]));
			end
		end
	end

	// Watchdog: any transaction on either side restarts the count.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("i2c_master_write_read_sequencer_tb: errors");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tuser        = '0;
		arst_n         = 1'b0;
		mismatches     = 0;
		items_sent     = 0;
		quiet_cycles   = 0;
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		seq_phase      = PH_IDLE;
		seq_dest       = '0;
		seq_wr_pos     = '0;
		seq_wr_left    = '0;
		seq_rd_left    = '0;
		seq_rd_pos     = '0;
		foreach (seq_loaded[i]) begin
			seq_loaded[i] = 1'b0;
			seq_store[i]  = '0;
		end
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		test_write_then_read();
		test_degenerate_requests();
		test_abort_paths();
		// Random traffic: back to back, then sender gaps, receiver stalls, and both.
		test_random_traffic(0, 0, 460);
		test_random_traffic(56, 0, 460);
		test_random_traffic(0, 56, 460);
		test_random_traffic(25, 25, 460);

		@(negedge clk) s_tvalid <= 1'b0;
		while (bus_actions_due.size() != 0)
			@(posedge clk);
		// Results trail their inputs through stage 1 and the output register; watch for strays.
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("i2c_master_write_read_sequencer_tb: clean");
		else
			$display("i2c_master_write_read_sequencer_tb: errors");
		$finish;
	end

endmodule
